FILE: hw/rtl/glu_pkg.sv
// Shared definitions for the GCD / LCM unit.
// No dependencies; used by glu_core.sv and gcd_lcm_unit_top.sv.
`default_nettype none

package glu_pkg;

    // Default operand width of the datapath.
    localparam int DEFAULT_VALUE_BITS = 31;

    // Top level to core.
    typedef struct packed {
        logic start;    // load operands, core must be idle
        logic ack;      // result taken, core leaves its done state
    } t_core_ctrl;

    // Core to top level.
    typedef struct packed {
        logic idle;     // ready for a new operand pair
        logic done;     // result valid, held until ack
    } t_core_stat;

endpackage

`default_nettype wire

FILE: hw/rtl/glu_core.sv
// Iterative GCD / LCM engine: binary GCD, restoring division a/g, shift-add multiply.
// One shared add/subtract unit under a small sequencer. Depends on glu_pkg.
`default_nettype none

module glu_core #(
    parameter int VALUE_BITS = glu_pkg::DEFAULT_VALUE_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire glu_pkg::t_core_ctrl       i_ctrl,
    input  wire logic [VALUE_BITS-1:0]     i_a_value,
    input  wire logic [VALUE_BITS-1:0]     i_b_value,
    output glu_pkg::t_core_stat            o_stat,
    output logic [VALUE_BITS-1:0]          o_gcd_value,
    output logic [2*VALUE_BITS-1:0]        o_lcm_value,
    output logic                           o_zero_error
);
    import glu_pkg::*;

    localparam int W  = VALUE_BITS;
    localparam int KW = $clog2(VALUE_BITS);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_TWOS    = 3'd1;
    localparam logic [2:0] S_XODD    = 3'd2;
    localparam logic [2:0] S_LOOP    = 3'd3;
    localparam logic [2:0] S_RESTORE = 3'd4;
    localparam logic [2:0] S_DIV     = 3'd5;
    localparam logic [2:0] S_MUL     = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0]      r_state;
    logic [W-1:0]    r_x;       // gcd working value, then the gcd itself
    logic [W-1:0]    r_y;
    logic [W-1:0]    r_a;       // dividend, shifts into quotient
    logic [W-1:0]    r_b;
    logic [W-1:0]    r_rem;
    logic [2*W-1:0]  r_prod;    // {upper, multiplier} during multiply
    logic [KW-1:0]   r_k;       // common factors of two
    logic [KW-1:0]   r_cnt;
    logic            r_zero;

    // Shared add/subtract unit
    logic [W:0]      add_a;
    logic [W:0]      add_b;
    logic            add_sub;
    logic [W+1:0]    add_res;

    logic            gt;
    logic [W:0]      rem_sh;
    logic            q_bit;
    logic [W-1:0]    q_next;
    logic [W:0]      mul_sum;

    assign gt     = (r_x > r_y);
    assign rem_sh = {r_rem, r_a[W-1]};

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (r_state)
            S_LOOP: begin
                add_a   = gt ? {1'b0, r_x} : {1'b0, r_y};
                add_b   = gt ? {1'b0, r_y} : {1'b0, r_x};
                add_sub = 1'b1;
            end
            S_DIV: begin
                add_a   = rem_sh;
                add_b   = {1'b0, r_x};
                add_sub = 1'b1;
            end
            S_MUL: begin
                add_a   = {1'b0, r_prod[2*W-1:W]};
                add_b   = {1'b0, r_b};
                add_sub = 1'b0;
            end
            default: begin
                add_a   = '0;
                add_b   = '0;
                add_sub = 1'b0;
            end
        endcase
    end

    assign add_res = add_sub ? ({1'b0, add_a} - {1'b0, add_b})
                             : ({1'b0, add_a} + {1'b0, add_b});

    // Restoring division step: borrow clear means the divisor fits
    assign q_bit   = ~add_res[W+1];
    assign q_next  = {r_a[W-2:0], q_bit};
    assign mul_sum = r_prod[0] ? add_res[W:0] : {1'b0, r_prod[2*W-1:W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctrl.start) begin
                        r_a <= i_a_value;
                        r_b <= i_b_value;
                        r_y <= i_b_value;
                        r_k <= '0;
                        if (i_a_value == '0 || i_b_value == '0) begin
                            r_zero  <= 1'b1;
                            r_x     <= '0;
                            r_prod  <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_zero  <= 1'b0;
                            r_x     <= i_a_value;
                            r_state <= S_TWOS;
                        end
                    end
                end
                S_TWOS: begin
                    if (r_x[0] || r_y[0]) begin
                        r_state <= S_XODD;
                    end else begin
                        r_x <= r_x >> 1;
                        r_y <= r_y >> 1;
                        r_k <= r_k + KW'(1);
                    end
                end
                S_XODD: begin
                    if (r_x[0]) begin
                        r_state <= S_LOOP;
                    end else begin
                        r_x <= r_x >> 1;
                    end
                end
                S_LOOP: begin
                    // x stays odd; y is halved until odd, then replaced by |x - y|
                    if (r_y == '0) begin
                        r_state <= S_RESTORE;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else begin
                        r_x <= gt ? r_y : r_x;
                        r_y <= add_res[W-1:0];
                    end
                end
                S_RESTORE: begin
                    if (r_k == '0) begin
                        r_rem   <= '0;
                        r_cnt   <= KW'(W - 1);
                        r_state <= S_DIV;
                    end else begin
                        r_x <= r_x << 1;
                        r_k <= r_k - KW'(1);
                    end
                end
                S_DIV: begin
                    r_rem <= q_bit ? add_res[W-1:0] : rem_sh[W-1:0];
                    r_a   <= q_next;
                    if (r_cnt == '0) begin
                        r_prod  <= {{W{1'b0}}, q_next};
                        r_cnt   <= KW'(W - 1);
                        r_state <= S_MUL;
                    end else begin
                        r_cnt <= r_cnt - KW'(1);
                    end
                end
                S_MUL: begin
                    r_prod <= {mul_sum, r_prod[W-1:1]};
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt - KW'(1);
                    end
                end
                S_DONE: begin
                    if (i_ctrl.ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stat.idle  = (r_state == S_IDLE);
    assign o_stat.done  = (r_state == S_DONE);
    assign o_gcd_value  = r_x;
    assign o_lcm_value  = r_prod;
    assign o_zero_error = r_zero;

endmodule

`default_nettype wire

FILE: hw/rtl/gcd_lcm_unit_top.sv
// GCD / LCM unit, top level: request channels, output register, iterative core.
// Depends on glu_pkg and glu_core.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request: two unsigned
//   operands i_a_value and i_b_value. Output channel (o_out_valid / i_out_ready)
//   returns one result per request: gcd, lcm at double width, and a zero flag.
//   A zero operand sets o_zero_error and returns zero gcd and lcm.
//   One request is worked on at a time. The core runs a binary GCD
//   (common-twos strip, odd reduction with one subtract per step, shift back),
//   then a restoring division a/gcd of VALUE_BITS steps and a shift-add
//   multiply of VALUE_BITS steps; the subtracts, the division and the
//   multiply share a single adder. A zero operand skips all of these and
//   goes straight to the result. o_in_ready is high while the core
//   is idle, so a new request can be taken while the previous result still
//   waits in the output register.
//   If the receiver stalls, the finished core holds its result until the
//   output register frees up.
//   Reset (i_rst_n low, synchronous) empties the output register and returns
//   the core to idle; no other state survives between requests.
`default_nettype none

module gcd_lcm_unit_top #(
    parameter int VALUE_BITS = glu_pkg::DEFAULT_VALUE_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // request channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [VALUE_BITS-1:0]     i_a_value,
    input  wire logic [VALUE_BITS-1:0]     i_b_value,
    // result channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [VALUE_BITS-1:0]          o_gcd_value,
    output logic [2*VALUE_BITS-1:0]        o_lcm_value,
    output logic                           o_zero_error
);
    import glu_pkg::*;

    t_core_ctrl                 core_ctrl;
    t_core_stat                 core_stat;
    logic [VALUE_BITS-1:0]      core_gcd;
    logic [2*VALUE_BITS-1:0]    core_lcm;
    logic                       core_zero;

    // Output register
    logic                       r_out_valid;
    logic [VALUE_BITS-1:0]      r_gcd;
    logic [2*VALUE_BITS-1:0]    r_lcm;
    logic                       r_zero;

    logic                       load_out;

    // Result moves into the output register when it is empty or being drained.
    assign load_out = core_stat.done && (!r_out_valid || i_out_ready);

    assign o_in_ready     = core_stat.idle;
    assign core_ctrl.start = i_in_valid && core_stat.idle;
    assign core_ctrl.ack   = load_out;

    glu_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (core_ctrl),
        .i_a_value    (i_a_value),
        .i_b_value    (i_b_value),
        .o_stat       (core_stat),
        .o_gcd_value  (core_gcd),
        .o_lcm_value  (core_lcm),
        .o_zero_error (core_zero)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_gcd  <= core_gcd;
            r_lcm  <= core_lcm;
            r_zero <= core_zero;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_gcd_value  = r_gcd;
    assign o_lcm_value  = r_lcm;
    assign o_zero_error = r_zero;

endmodule

`default_nettype wire

FILE: test/gcd_lcm_unit_top_test.sv
// Testbench for gcd_lcm_unit_top: random and directed operand pairs, checked
// against an in-bench GCD / LCM calculation. Depends on glu_pkg and the RTL.
`timescale 1ns / 1ps

module gcd_lcm_unit_top_test;

    localparam int VB = glu_pkg::DEFAULT_VALUE_BITS;
    localparam int unsigned MAXV = (1 << VB) - 1;

    typedef struct packed {
        logic [VB-1:0]   gcd;
        logic [2*VB-1:0] lcm;
        logic            zero_err;
    } t_gcd_lcm;

    // Holds the results still owed by the block, oldest first.
    class gcd_lcm_board;
        t_gcd_lcm    owed[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Euclid for the GCD, then (a / gcd) * b at double width.
        static function t_gcd_lcm calc_gcd_lcm(logic [VB-1:0] a, logic [VB-1:0] b);
            t_gcd_lcm        res;
            logic [VB-1:0]   x;
            logic [VB-1:0]   y;
            logic [VB-1:0]   rem;
            logic [2*VB-1:0] quot;
            logic [2*VB-1:0] wide_b;
            res = '0;
            if (a == '0 || b == '0) begin
                res.zero_err = 1'b1;
                return res;
            end
            x = a;
            y = b;
            while (y != '0) begin
                rem = x % y;
                x = y;
                y = rem;
            end
            quot = a / x;
            wide_b = b;
            res.gcd = x;
            res.lcm = quot * wide_b;
            return res;
        endfunction

        function void note_request(logic [VB-1:0] a, logic [VB-1:0] b);
            owed.insert(owed.size(), calc_gcd_lcm(a, b));
        endfunction

        function void check_result(logic [VB-1:0] g, logic [2*VB-1:0] l, logic z);
            t_gcd_lcm want;
            if (owed.size() == 0) begin
                $error("result with no request outstanding: gcd %0d lcm %0d zero_error %0b",
                       g, l, z);
                mismatches++;
                return;
            end
            want = owed.pop_front();
            if (g !== want.gcd) begin
                $error("gcd_value: expected %0d, got %0d", want.gcd, g);
                mismatches++;
            end
            if (l !== want.lcm) begin
                $error("lcm_value: expected %0d, got %0d", want.lcm, l);
                mismatches++;
            end
            if (z !== want.zero_err) begin
                $error("zero_error: expected %0b, got %0b", want.zero_err, z);
                mismatches++;
            end
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_in_valid = 1'b0;
    logic            o_in_ready;
    logic [VB-1:0]   i_a_value = '0;
    logic [VB-1:0]   i_b_value = '0;
    logic            o_out_valid;
    logic            i_out_ready = 1'b0;
    logic [VB-1:0]   o_gcd_value;
    logic [2*VB-1:0] o_lcm_value;
    logic            o_zero_error;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    gcd_lcm_board board;

    gcd_lcm_unit_top #(
        .VALUE_BITS(VB)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_a_value    (i_a_value),
        .i_b_value    (i_b_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_gcd_value  (o_gcd_value),
        .o_lcm_value  (o_lcm_value),
        .o_zero_error (o_zero_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side stalls independently of o_out_valid.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Both handshakes are observed in one process: request first, then result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                board.note_request(i_a_value, i_b_value);
            if (o_out_valid && i_out_ready)
                board.check_result(o_gcd_value, o_lcm_value, o_zero_error);
        end
    end

    // Presents one request and returns at the edge where it is taken.
    // Valid stays high between back-to-back requests.
    task automatic send_request(input int unsigned a, input int unsigned b);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_a_value  <= VB'(a);
        i_b_value  <= VB'(b);
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Operand mix: full-range noise, shared factors, many trailing zeros
    // (binary GCD shift path), small values, multiples, and a few zeros.
    task automatic send_random_request();
        int unsigned kind;
        int unsigned g;
        int unsigned a;
        int unsigned b;
        int unsigned t;
        kind = $urandom_range(99);
        if (kind < 3) begin
            a = $urandom() & MAXV;
            b = 0;
            if ($urandom_range(1)) begin
                b = a;
                a = 0;
            end
        end else if (kind < 28) begin
            a = $urandom() & MAXV;
            b = $urandom() & MAXV;
        end else if (kind < 55) begin
            g = 1 + ($urandom() >> $urandom_range(31, 7));
            a = g * $urandom_range(MAXV / g, 1);
            b = g * $urandom_range(MAXV / g, 1);
        end else if (kind < 72) begin
            a = (($urandom() | 1) << $urandom_range(VB - 1, 0)) & MAXV;
            b = (($urandom() | 1) << $urandom_range(VB - 1, 0)) & MAXV;
        end else if (kind < 82) begin
            a = $urandom_range(255, 1);
            b = $urandom_range(255, 1);
        end else if (kind < 94) begin
            a = 1 + (($urandom() & MAXV) >> $urandom_range(VB - 1, 1));
            b = a * $urandom_range(MAXV / a, 1);
            if ($urandom_range(1)) begin
                t = a;
                a = b;
                b = t;
            end
        end else begin
            a = 1 + ($urandom() & (MAXV >> 1));
            b = $urandom_range(1) ? a : 1;
        end
        send_request(a, b);
    endtask

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        board = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 34;
        recv_idle_pct = 48;

        // zero operands on either side and both
        send_request(0, 0);
        send_request(0, 5);
        send_request(7, 0);
        send_request(MAXV, 0);
        send_request(0, MAXV);
        // unit and extreme operands
        send_request(1, 1);
        send_request(1, MAXV);
        send_request(MAXV, 1);
        send_request(MAXV, MAXV);
        send_request(MAXV, MAXV - 1);
        send_request(MAXV - 1, MAXV);
        // two large primes: lcm is their full product
        send_request(MAXV, 2147483629);
        // powers of two, common twos stripped and shifted back
        send_request(1 << (VB - 1), 1 << (VB - 1));
        send_request(1 << (VB - 1), 3 << 20);
        send_request(1 << (VB - 1), 1);
        send_request(MAXV - 1, 1 << (VB - 1));
        // ordinary small cases
        send_request(12, 18);
        send_request(18, 12);
        send_request(6, 4);
        send_request(1, 2);
        send_request(30030, 510510);

        repeat (417) send_random_request();

        send_idle_pct = 48;
        recv_idle_pct = 34;
        repeat (417) send_random_request();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (416) send_random_request();
        i_in_valid <= 1'b0;

        // let the monitor note the last request before draining
        @(posedge i_clk);
        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (8 * VB) @(posedge i_clk);

        if (board.mismatches == 0 && board.owed.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/glu_pkg.sv
hw/rtl/glu_core.sv
hw/rtl/gcd_lcm_unit_top.sv
test/gcd_lcm_unit_top_test.sv
